[rtl/core/two_island_min_gap_assert.svh]
// Assertion macros used by the engine RTL file of the two-island gap block.
`ifndef TWO_ISLAND_MIN_GAP_ASSERT_SVH
`define TWO_ISLAND_MIN_GAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define TIG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define TIG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TIG_ASSERT(label, prop, msg)
`define TIG_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/core/tig_pkg.sv]
// Types and constants shared by the two-island gap block.
`timescale 1ns / 1ps
package tig_pkg;
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int RW       = $clog2(MAX_ROWS);
  localparam int CW       = $clog2(MAX_COLS);
  localparam int AW       = RW + CW;
  localparam int CELLS    = 1 << AW;
  localparam int CNT_W    = AW + 1;
  localparam int DW       = ((RW > CW) ? RW : CW) + 1;
  localparam int GAP_W    = 6;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 2'd0,
    REG_NUM_COLS = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_LOAD, S_SCAN_RD, S_SCAN_CHK, S_POP, S_POP_WAIT, S_NB, S_NB_CHK,
    S_PA, S_PA_W, S_PB, S_EMIT
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [GAP_W-1:0] gap;
  } res_t;
endpackage

[rtl/core/tig_ram.sv]
// Single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module tig_ram #(
  parameter int W = 10,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/core/tig_engine.sv]
// Sequencer: grid load, scan, stack flood fill and pairwise distance search.
`timescale 1ns / 1ps
`include "two_island_min_gap_assert.svh"
module tig_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [tig_pkg::RW-1:0] row_last,
  input  logic [tig_pkg::CW-1:0] col_last,
  input  logic                   restart,
  input  logic                   in_valid,
  input  logic                   in_land,
  output logic                   in_ready,
  output tig_pkg::res_t          res,
  input  logic                   res_take
);
  import tig_pkg::*;

  state_t state, state_next;
  logic [RW-1:0] r, r_next;
  logic [CW-1:0] c, c_next;
  logic [CNT_W-1:0] sp, sp_next, a_cnt, a_cnt_next, b_cnt, b_cnt_next;
  logic [CNT_W-1:0] i, i_next, j, j_next;
  logic got_a, got_a_next, found, found_next, rd_v, rd_v_next;
  logic [AW-1:0] cur, cur_next, a_cell, a_cell_next;
  logic [1:0] nb, nb_next;
  logic [DW-1:0] best, best_next;

  logic land_we, land_wd, land_rd;
  logic [AW-1:0] land_addr;
  logic stk_we;
  logic [AW-1:0] stk_addr, stk_wd, stk_rd;
  logic a_we, b_we;
  logic [AW-1:0] a_addr, b_addr, a_rd, b_rd;

  logic last_cell, nb_ok;
  logic [AW-1:0] nb_addr;
  logic [RW-1:0] cur_r;
  logic [CW-1:0] cur_c;
  logic [DW-1:0] dr, dc, pair_dist;
  logic [DW-1:0] best_m1;

  tig_ram #(.W(1), .D(CELLS)) u_land (
    .clk(clk), .we(land_we), .addr(land_addr), .wdata(land_wd), .rdata(land_rd));
  tig_ram #(.W(AW), .D(CELLS)) u_stack (
    .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wd), .rdata(stk_rd));
  tig_ram #(.W(AW), .D(CELLS)) u_list_a (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(stk_rd), .rdata(a_rd));
  tig_ram #(.W(AW), .D(CELLS)) u_list_b (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(stk_rd), .rdata(b_rd));

  assign last_cell = (r == row_last) && (c == col_last);
  assign cur_r = cur[AW-1:CW];
  assign cur_c = cur[CW-1:0];

  // Neighbor of the popped cell selected by nb: down, up, left, right.
  always_comb begin
    nb_ok   = 1'b0;
    nb_addr = cur;
    case (nb)
      2'd0: begin
        nb_ok   = (cur_r != row_last);
        nb_addr = {cur_r + RW'(1), cur_c};
      end
      2'd1: begin
        nb_ok   = (cur_r != '0);
        nb_addr = {cur_r - RW'(1), cur_c};
      end
      2'd2: begin
        nb_ok   = (cur_c != '0);
        nb_addr = {cur_r, cur_c - CW'(1)};
      end
      default: begin
        nb_ok   = (cur_c != col_last);
        nb_addr = {cur_r, cur_c + CW'(1)};
      end
    endcase
  end

  // Manhattan distance between the held A cell and the B cell just read.
  always_comb begin
    logic [RW-1:0] ar, br;
    logic [CW-1:0] ac, bc;
    ar = a_cell[AW-1:CW];
    ac = a_cell[CW-1:0];
    br = b_rd[AW-1:CW];
    bc = b_rd[CW-1:0];
    dr = (ar > br) ? DW'(ar - br) : DW'(br - ar);
    dc = (ac > bc) ? DW'(ac - bc) : DW'(bc - ac);
    pair_dist = dr + dc;
  end

  assign best_m1 = best - DW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      r     <= '0;
      c     <= '0;
      sp    <= '0;
      a_cnt <= '0;
      b_cnt <= '0;
      got_a <= 1'b0;
      found <= 1'b0;
      rd_v  <= 1'b0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      sp    <= sp_next;
      a_cnt <= a_cnt_next;
      b_cnt <= b_cnt_next;
      got_a <= got_a_next;
      found <= found_next;
      rd_v  <= rd_v_next;
    end
    i      <= i_next;
    j      <= j_next;
    cur    <= cur_next;
    a_cell <= a_cell_next;
    nb     <= nb_next;
    best   <= best_next;
  end

  always_comb begin
    state_next  = state;
    r_next      = r;
    c_next      = c;
    sp_next     = sp;
    a_cnt_next  = a_cnt;
    b_cnt_next  = b_cnt;
    got_a_next  = got_a;
    found_next  = found;
    rd_v_next   = 1'b0;
    i_next      = i;
    j_next      = j;
    cur_next    = cur;
    a_cell_next = a_cell;
    nb_next     = nb;
    best_next   = best;
    land_we     = 1'b0;
    land_wd     = 1'b0;
    land_addr   = {r, c};
    stk_we      = 1'b0;
    stk_addr    = sp[AW-1:0];
    stk_wd      = {r, c};
    a_we        = 1'b0;
    b_we        = 1'b0;
    a_addr      = a_cnt[AW-1:0];
    b_addr      = b_cnt[AW-1:0];
    in_ready    = 1'b0;
    res.valid   = 1'b0;
    res.found   = found;
    res.gap     = '0;

    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (restart) begin
          r_next = '0;
          c_next = '0;
        end else if (in_valid) begin
          land_we = 1'b1;
          land_wd = in_land;
          if (c == col_last) begin
            c_next = '0;
            if (r == row_last) begin
              r_next     = '0;
              got_a_next = 1'b0;
              found_next = 1'b0;
              a_cnt_next = '0;
              b_cnt_next = '0;
              state_next = S_SCAN_RD;
            end else begin
              r_next = r + RW'(1);
            end
          end else begin
            c_next = c + CW'(1);
          end
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (land_rd) begin
          land_we    = 1'b1;
          stk_we     = 1'b1;
          stk_addr   = '0;
          sp_next    = CNT_W'(1);
          state_next = S_POP;
        end else if (last_cell) begin
          state_next = S_EMIT;
        end else begin
          if (c == col_last) begin
            c_next = '0;
            r_next = r + RW'(1);
          end else begin
            c_next = c + CW'(1);
          end
          state_next = S_SCAN_RD;
        end
      end
      S_POP: begin
        if (sp == '0) begin
          if (got_a) begin
            found_next = 1'b1;
            i_next     = '0;
            best_next  = '1;
            state_next = S_PA;
          end else begin
            got_a_next = 1'b1;
            if (last_cell) begin
              state_next = S_EMIT;
            end else begin
              if (c == col_last) begin
                c_next = '0;
                r_next = r + RW'(1);
              end else begin
                c_next = c + CW'(1);
              end
              state_next = S_SCAN_RD;
            end
          end
        end else begin
          stk_addr   = AW'(sp - CNT_W'(1));
          sp_next    = sp - CNT_W'(1);
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cur_next = stk_rd;
        if (got_a) begin
          b_we       = 1'b1;
          b_cnt_next = b_cnt + CNT_W'(1);
        end else begin
          a_we       = 1'b1;
          a_cnt_next = a_cnt + CNT_W'(1);
        end
        nb_next    = 2'd0;
        state_next = S_NB;
      end
      S_NB: begin
        land_addr = nb_addr;
        if (nb_ok) begin
          state_next = S_NB_CHK;
        end else if (nb == 2'd3) begin
          state_next = S_POP;
        end else begin
          nb_next = nb + 2'd1;
        end
      end
      S_NB_CHK: begin
        land_addr = nb_addr;
        stk_wd    = nb_addr;
        if (land_rd) begin
          land_we = 1'b1;
          stk_we  = 1'b1;
          sp_next = sp + CNT_W'(1);
        end
        if (nb == 2'd3) begin
          state_next = S_POP;
        end else begin
          nb_next    = nb + 2'd1;
          state_next = S_NB;
        end
      end
      S_PA: begin
        a_addr     = i[AW-1:0];
        state_next = S_PA_W;
      end
      S_PA_W: begin
        a_cell_next = a_rd;
        j_next      = '0;
        state_next  = S_PB;
      end
      S_PB: begin
        b_addr = j[AW-1:0];
        if (j != b_cnt) begin
          j_next    = j + CNT_W'(1);
          rd_v_next = 1'b1;
        end
        if (rd_v && (pair_dist < best)) begin
          best_next = pair_dist;
        end
        if ((j == b_cnt) && !rd_v) begin
          i_next = i + CNT_W'(1);
          if (i + CNT_W'(1) == a_cnt) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_PA;
          end
        end
      end
      S_EMIT: begin
        res.valid = 1'b1;
        if (found) begin
          res.gap = (32'(best_m1) > 63) ? '1 : GAP_W'(best_m1);
        end
        if (res_take) begin
          r_next     = '0;
          c_next     = '0;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  `TIG_ASSERT(a_sp_bound, (32'(sp) <= CELLS), "fill stack pointer beyond depth")
  `TIG_ASSERT(a_push_count, (state == S_NB_CHK && land_rd) |=> (sp == $past(sp) + CNT_W'(1)),
    "land neighbor not pushed")
  `TIG_ASSERT(a_pair_nonempty, (state == S_PA) |-> (a_cnt != '0 && b_cnt != '0),
    "pair search started with an empty island")
endmodule

[rtl/core/two_island_min_gap.sv]
// Top level of the two-island gap block: ports, configuration and result register.
`timescale 1ns / 1ps
// Usage:
// The grid arrives on the slave stream, one cell per transaction in row-major
// order, with the land bit in s_tdata bit 0. The grid size comes from two
// configuration registers, num_rows (index 0) and num_cols (index 1), written
// over the cfg channel while the block is idle; a write also restarts loading
// at the first cell. A value of zero counts as one, a value above 32 as 32.
// Loading takes one cell per cycle while the block is loading; s_tready is
// low while it scans, searches or holds a result. After the last cell the
// block scans the stored grid, flood-fills the first two islands with a stack
// in RAM, then compares every cell pair through the single port of each
// on-chip RAM. One result transaction follows: the gap on m_tdata and the
// found flag on m_tuser. The result sits in an output register, so the next
// grid may load while the receiver stalls; a second result waits until the
// first one has been taken. Reset returns the block to loading with both
// sizes at 32; the grid RAMs are not cleared.
module two_island_min_gap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [0] land, [7:1] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [5:0] gap, [7:6] zero
  output logic                          m_tuser,   // [0] found
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tig_pkg::CFG_W-1:0]     cfg_data
);
  import tig_pkg::*;

  logic [CFG_W-1:0] num_rows, num_cols;
  logic [RW-1:0] row_last;
  logic [CW-1:0] col_last;
  logic cfg_we, res_take;
  res_t res;
  logic [GAP_W-1:0] gap;
  logic found;

  // Configuration is always taken; it must arrive only while idle (unenforced).
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready &&
                  (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= CFG_W'(MAX_ROWS);
      num_cols <= CFG_W'(MAX_COLS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Index of the last row and column in use, after clamping the registers.
  always_comb begin
    if (num_rows == '0) begin
      row_last = '0;
    end else if (32'(num_rows) > MAX_ROWS) begin
      row_last = RW'(MAX_ROWS - 1);
    end else begin
      row_last = RW'(32'(num_rows) - 1);
    end
    if (num_cols == '0) begin
      col_last = '0;
    end else if (32'(num_cols) > MAX_COLS) begin
      col_last = CW'(MAX_COLS - 1);
    end else begin
      col_last = CW'(32'(num_cols) - 1);
    end
  end

  tig_engine u_engine (
    .clk(clk), .rst(rst), .row_last(row_last), .col_last(col_last),
    .restart(cfg_we), .in_valid(s_tvalid), .in_land(s_tdata[0]),
    .in_ready(s_tready), .res(res), .res_take(res_take));

  // Output register: free when empty or being drained this cycle.
  assign res_take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= res.valid;
    end
    if (res_take && res.valid) begin
      gap   <= res.gap;
      found <= res.found;
    end
  end

  assign m_tdata = {2'b00, gap};
  assign m_tuser = found;
endmodule

[tb/tb.sv]
// Self-checking testbench for the two-island gap block: grid stimulus, prediction, checking.
`timescale 1ns / 1ps
module tb;
  import tig_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NUM_ROWS;
  logic [CFG_W-1:0] cfg_data = '0;

  two_island_min_gap u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [GAP_W-1:0] gap;
    logic             found;
  } bridge_t;

  // Grid cells waiting to be sent, and the bridge results still owed by the block.
  bit      cell_queue[$];
  bridge_t bridge_queue[$];
  int      mismatches = 0;
  int      hold_cycles = 0;  // long receiver hold-off, set by the stimulus

  // Predictor state: its own copy of the sizes, the loaded grid and the load position.
  int unsigned rows_reg = 32;
  int unsigned cols_reg = 32;
  int unsigned load_pos = 0;
  bit grid[CELLS];
  int unsigned fill_stack[CELLS];
  int unsigned isl_a[CELLS];
  int unsigned isl_b[CELLS];

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Appends one cell to the tail of the pending stimulus.
  function automatic void add_cell(bit v);
    cell_queue.insert(cell_queue.size(), v);
  endfunction

  // Stack-based 4-connected fill from a seed; clears collected cells in the grid.
  function automatic int unsigned fill_island(int unsigned seed, bit to_b,
                                              int unsigned nr, int unsigned nc);
    int unsigned depth, cnt, p, r, c;
    int unsigned nb[4];
    bit ok[4];
    depth = 0;
    cnt = 0;
    grid[seed] = 1'b0;
    fill_stack[depth++] = seed;
    while (depth > 0) begin
      depth--;
      p = fill_stack[depth];
      if (to_b) isl_b[cnt] = p;
      else isl_a[cnt] = p;
      cnt++;
      r = p / nc;
      c = p % nc;
      nb[0] = p + nc; ok[0] = (r + 1 < nr);
      nb[1] = p - nc; ok[1] = (r > 0);
      nb[2] = p - 1;  ok[2] = (c > 0);
      nb[3] = p + 1;  ok[3] = (c + 1 < nc);
      for (int k = 0; k < 4; k++) begin
        if (ok[k] && grid[nb[k]]) begin
          grid[nb[k]] = 1'b0;
          fill_stack[depth++] = nb[k];
        end
      end
    end
    return cnt;
  endfunction

  // Takes one accepted cell; after the last cell of the grid it queues the bridge result.
  function automatic void predict_cell(bit land);
    int unsigned nr, nc, total, na, nbc, best, d, ar, ac, br, bc;
    bit got_a, got_b;
    bridge_t res;
    nr = clamp_size(rows_reg, MAX_ROWS);
    nc = clamp_size(cols_reg, MAX_COLS);
    total = nr * nc;
    if (load_pos >= total) load_pos = 0;
    grid[load_pos] = land;
    load_pos++;
    if (load_pos < total) return;
    load_pos = 0;
    got_a = 0; got_b = 0; na = 0; nbc = 0;
    for (int unsigned i = 0; i < total && !got_b; i++) begin
      if (grid[i]) begin
        if (!got_a) begin
          na = fill_island(i, 1'b0, nr, nc);
          got_a = 1;
        end else begin
          nbc = fill_island(i, 1'b1, nr, nc);
          got_b = 1;
        end
      end
    end
    if (!got_b) begin
      res.gap = '0;
      res.found = 1'b0;
    end else begin
      best = 32'hFFFF_FFFF;
      for (int unsigned i = 0; i < na; i++) begin
        ar = isl_a[i] / nc; ac = isl_a[i] % nc;
        for (int unsigned j = 0; j < nbc; j++) begin
          br = isl_b[j] / nc; bc = isl_b[j] % nc;
          d = ((ar > br) ? ar - br : br - ar) + ((ac > bc) ? ac - bc : bc - ac);
          if (d < best) best = d;
        end
      end
      best = (best > 0) ? best - 1 : 0;
      if (best > 63) best = 63;
      res.gap = best[GAP_W-1:0];
      res.found = 1'b1;
    end
    bridge_queue.insert(bridge_queue.size(), res);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: offers queued cells with a random gap before each one.
  int send_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait <= $urandom_range(0, 8);
    end else if (s_tvalid && s_tready) begin
      // The predictor follows the accepted transaction in the same step.
      predict_cell(s_tdata[0]);
      void'(cell_queue.pop_front());
      if (cell_queue.size() > 0 && $urandom_range(0, 8) == 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, cell_queue[0]};
      end else begin
        s_tvalid <= 1'b0;
        send_wait <= (cell_queue.size() > 0 && $urandom_range(0, 3) == 0) ?
                     $urandom_range(1, 8) : 0;
      end
    end else if (!s_tvalid && cell_queue.size() > 0) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, cell_queue[0]};
      end
    end
  end

  // Monitor: random receiver stalls, a long hold-off on request, and result checks.
  int recv_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (bridge_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result gap=%0d found=%0d", m_tdata[5:0], m_tuser);
        end else begin
          if (m_tdata[5:0] !== bridge_queue[0].gap || m_tuser !== bridge_queue[0].found ||
              m_tdata[7:6] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected gap=%0d found=%0d, got gap=%0d found=%0d",
                       bridge_queue[0].gap, bridge_queue[0].found, m_tdata[5:0], m_tuser);
          end
          void'(bridge_queue.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        recv_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
        m_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Waits until every queued cell went in and every result came out, plus the drain time.
  task automatic drain();
    while (cell_queue.size() > 0 || bridge_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write over the configuration channel; only called while idle.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_NUM_ROWS) rows_reg = val;
    else cols_reg = val;
    load_pos = 0;
    @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
    drain();
    write_reg(REG_NUM_ROWS, r);
    write_reg(REG_NUM_COLS, c);
  endtask

  // Queues one grid; density in percent decides how much land it holds.
  task automatic queue_grid(int unsigned n, int unsigned density);
    for (int unsigned i = 0; i < n; i++)
      add_cell($urandom_range(0, 99) < density);
  endtask

  int unsigned sent;
  int unsigned nr, nc;
  int unsigned reps;
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: a single cell, all water, all land, two separated islands.
    set_size(6'd0, 6'd0);             // zero is taken as a one by one grid
    add_cell(1'b1);
    add_cell(1'b0);
    set_size(6'd1, 6'd4);
    add_cell(1'b1); add_cell(1'b0);
    add_cell(1'b0); add_cell(1'b1);
    add_cell(1'b1); add_cell(1'b1);
    add_cell(1'b1); add_cell(1'b1);
    set_size(6'd3, 6'd3);
    queue_grid(9, 0);
    // Configuration write in the middle of a grid restarts the load.
    drain();
    add_cell(1'b1); add_cell(1'b1);
    drain();
    write_reg(REG_NUM_COLS, 6'd3);
    add_cell(1'b1); add_cell(1'b0); add_cell(1'b0);
    queue_grid(3, 0);
    add_cell(1'b0); add_cell(1'b0); add_cell(1'b1);

    // Oversized sizes are clamped to the maximum: one full grid, islands at far corners.
    set_size(6'd63, 6'd40);
    add_cell(1'b1);
    queue_grid(1022, 0);
    add_cell(1'b1);

    // Pressure: receiver holds off while several small grids are pushed through.
    set_size(6'd2, 6'd2);
    drain();
    hold_cycles = 400;
    for (int k = 0; k < 30; k++) queue_grid(4, 50);

    // Random part: mostly small grids of varied density, a rare large one.
    sent = 0;
    while (sent < 500) begin
      nr = $urandom_range(1, 8);
      nc = $urandom_range(1, 8);
      reps = $urandom_range(1, 4);
      if ($urandom_range(0, 40) == 0) begin
        nr = $urandom_range(16, 32);
        nc = $urandom_range(16, 32);
        reps = 1;
      end
      set_size(nr[CFG_W-1:0], nc[CFG_W-1:0]);
      for (int unsigned g = 0; g < reps; g++) begin
        queue_grid(nr * nc, $urandom_range(10, 70));
        sent += nr * nc;
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end
endmodule
